### hw/rtl/mffp_pkg.sv
package mffp_pkg;

	// parse phases, encoded so that a simple field's phase equals its record kind
	typedef enum logic [4:0] {
		PH_OPC      = 5'd0,
		PH_TS       = 5'd1,
		PH_GFLAGS   = 5'd2,
		PH_GSTART   = 5'd3,
		PH_GLEN     = 5'd4,
		PH_SYNC     = 5'd5,
		PH_SETCNT   = 5'd6,
		PH_BITMAP   = 5'd7,
		PH_QREP     = 5'd8,
		PH_RR_FLAGS = 5'd9,
		PH_RR_PEND  = 5'd10,
		PH_R_PORT   = 5'd11,
		PH_R_FLAGS  = 5'd12,
		PH_R_SYNC   = 5'd13,
		PH_R_PEND   = 5'd14,
		PH_A_FLAGS  = 5'd15,
		PH_A_PORT   = 5'd16,
		PH_A_SYNC   = 5'd17,
		PH_SKIP     = 5'd18
	} phase_t;

	// record kinds
	localparam logic [4:0] KIND_OPCODE = 5'd0;
	localparam logic [4:0] KIND_TS     = 5'd1;
	localparam logic [4:0] KIND_GFLAGS = 5'd2;
	localparam logic [4:0] KIND_GSTART = 5'd3;
	localparam logic [4:0] KIND_GLEN   = 5'd4;
	localparam logic [4:0] KIND_SETCNT = 5'd6;
	localparam logic [4:0] KIND_BITMAP = 5'd7;
	localparam logic [4:0] KIND_QREP   = 5'd8;
	localparam logic [4:0] KIND_END_OK = 5'd18;
	localparam logic [4:0] KIND_TRUNC  = 5'd19;

	// opcodes
	localparam logic [15:0] OP_PAUSE   = 16'h0001;
	localparam logic [15:0] OP_GATE    = 16'h0002;
	localparam logic [15:0] OP_REPORT  = 16'h0003;
	localparam logic [15:0] OP_REG_REQ = 16'h0004;
	localparam logic [15:0] OP_REG     = 16'h0005;
	localparam logic [15:0] OP_REG_ACK = 16'h0006;

	localparam logic [2:0] GRANT_MASK = 3'h7;

	// one output record
	typedef struct packed {
		logic [4:0]  kind;
		logic [7:0]  set_num;
		logic [3:0]  item_num;
		logic [31:0] value;
		logic        last;
	} record_t;

	// bytes per field for each phase
	function automatic logic [2:0] field_len(input phase_t ph);
		logic [2:0] len;
		unique case (ph)
			PH_TS, PH_GSTART:                          len = 3'd4;
			PH_OPC, PH_GLEN, PH_SYNC, PH_QREP,
			PH_R_PORT, PH_R_SYNC, PH_A_PORT, PH_A_SYNC: len = 3'd2;
			PH_SKIP:                                    len = 3'd0;
			default:                                    len = 3'd1;
		endcase
		return len;
	endfunction

	// queue number plus one of the lowest set bit, zero when none
	function automatic logic [3:0] lowest_queue(input logic [7:0] bits);
		logic [3:0] q;
		q = 4'd0;
		for (int i = 7; i >= 0; i--) begin
			if (bits[i]) begin
				q = 4'(i + 1);
			end
		end
		return q;
	endfunction

endpackage

### hw/rtl/mpcp_frame_field_parser.sv
// MPCP frame field parser.
// Input channel: one frame byte per beat (data_byte, frame_end marks the
// last byte), taken while in_valid is high and in_stall is low.
// Output channel: one record per beat (field_kind, set_number, item_number,
// value, last); the receiver holds it with out_stall.
// Config channel: cfg_data is the verbose bit, written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Each byte is decoded in the cycle it is taken; its records are registered
// into the output queue and reach the output in order behind older records.
// Throughput is one byte per cycle while in_stall is low. A byte that
// completes a recorded field and ends the frame yields two records, in that order.
// in_stall rises when the output queue (DEPTH records) has fewer than two
// free entries, so a receiver stall backs up into the input after the
// queue fills.
// Reset empties the queue, returns the parser to expecting an opcode and
// sets verbose to 1.
module mpcp_frame_field_parser #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  field_kind,
	output logic [7:0]  set_number,
	output logic [3:0]  item_number,
	output logic [31:0] value,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic              verbose_q;
	logic              in_beat, out_beat, room;
	logic              rec0_valid, rec1_valid;
	mffp_pkg::record_t rec0, rec1, head;

	assign in_stall  = !room;
	assign in_beat   = in_valid && !in_stall;
	assign out_beat  = out_valid && !out_stall;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verbose_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			verbose_q <= cfg_data;
		end
	end

	// byte decode
	mffp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_beat),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.verbose    (verbose_q),
		.rec0       (rec0),
		.rec0_valid (rec0_valid),
		.rec1       (rec1),
		.rec1_valid (rec1_valid)
	);

	// output queue
	mffp_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr0       (in_beat && rec0_valid),
		.wdata0    (rec0),
		.wr1       (in_beat && rec1_valid),
		.wdata1    (rec1),
		.rd        (out_beat),
		.rdata     (head),
		.not_empty (out_valid),
		.room      (room)
	);

	assign field_kind  = head.kind;
	assign set_number  = head.set_num;
	assign item_number = head.item_num;
	assign value       = head.value;
	assign last        = head.last;

`ifndef SYNTHESIS
	// end records and only they carry last
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (field_kind == mffp_pkg::KIND_END_OK ||
			field_kind == mffp_pkg::KIND_TRUNC)))
		else $error("last flag does not match record kind");

	// set number only on report bitmap and queue records
	a_set_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && set_number != 8'd0) |->
			(field_kind == mffp_pkg::KIND_BITMAP || field_kind == mffp_pkg::KIND_QREP))
		else $error("set number on a record without a queue set");

	// item number only on grants and queue reports
	a_item_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_number != 4'd0) |->
			(field_kind == mffp_pkg::KIND_GSTART || field_kind == mffp_pkg::KIND_GLEN ||
			field_kind == mffp_pkg::KIND_QREP))
		else $error("item number on a record without grant or queue");

	// a record from an accepted byte always reaches the output queue by the next cycle
	a_rec_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && rec0_valid) |=> out_valid)
		else $error("record lost after accepted byte");
`endif

endmodule

### hw/rtl/mffp_core.sv
module mffp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               frame_end,
	input  logic               verbose,
	output mffp_pkg::record_t  rec0,
	output logic               rec0_valid,
	output mffp_pkg::record_t  rec1,
	output logic               rec1_valid
);

	mffp_pkg::phase_t phase_q, phase_d, phase_adv;
	logic [2:0]  bif_q, bif_d, bif_inc;
	logic [31:0] acc_q, acc_d, acc_sh;
	logic [15:0] opcode_q, opcode_d;
	logic [2:0]  grants_q, grants_d;
	logic [2:0]  grant_q, grant_d;
	logic [7:0]  sets_q, sets_d;
	logic [7:0]  set_q, set_d;
	logic [7:0]  bitmap_q, bitmap_d, bm_clr, bm_src;
	logic [3:0]  queue_q, queue_d, low_idx;
	logic        done;
	mffp_pkg::record_t r_end;

	// field assembly and queue selection
	always_comb begin
		acc_sh  = {acc_q[23:0], data_byte};
		bif_inc = bif_q + 3'd1;
		done    = (phase_q != mffp_pkg::PH_SKIP) &&
			(bif_inc >= mffp_pkg::field_len(phase_q));

		// bitmap after the current queue is reported
		bm_clr = bitmap_q;
		if (queue_q >= 4'd1 && queue_q <= 4'd8) begin
			bm_clr = bitmap_q & ~(8'd1 << (queue_q - 4'd1));
		end
		bm_src  = (phase_q == mffp_pkg::PH_BITMAP) ? acc_sh[7:0] : bm_clr;
		low_idx = mffp_pkg::lowest_queue(bm_src);
	end

	// next parse state
	always_comb begin
		phase_adv = phase_q;
		bif_d     = bif_q;
		acc_d     = acc_q;
		opcode_d  = opcode_q;
		grants_d  = grants_q;
		grant_d   = grant_q;
		sets_d    = sets_q;
		set_d     = set_q;
		bitmap_d  = bitmap_q;
		queue_d   = queue_q;

		if (phase_q != mffp_pkg::PH_SKIP) begin
			acc_d = acc_sh;
			bif_d = bif_inc;
		end

		// field complete
		if (done) begin
			acc_d = '0;
			bif_d = '0;
			unique case (phase_q)
				mffp_pkg::PH_OPC: begin
					opcode_d  = acc_sh[15:0];
					phase_adv = mffp_pkg::PH_TS;
				end
				mffp_pkg::PH_TS: begin
					if (!verbose) begin
						phase_adv = mffp_pkg::PH_SKIP;
					end else if (opcode_q == mffp_pkg::OP_GATE) begin
						phase_adv = mffp_pkg::PH_GFLAGS;
					end else if (opcode_q == mffp_pkg::OP_REPORT) begin
						phase_adv = mffp_pkg::PH_SETCNT;
					end else if (opcode_q == mffp_pkg::OP_REG_REQ) begin
						phase_adv = mffp_pkg::PH_RR_FLAGS;
					end else if (opcode_q == mffp_pkg::OP_REG) begin
						phase_adv = mffp_pkg::PH_R_PORT;
					end else if (opcode_q == mffp_pkg::OP_REG_ACK) begin
						phase_adv = mffp_pkg::PH_A_FLAGS;
					end else begin
						phase_adv = mffp_pkg::PH_SKIP;
					end
				end
				mffp_pkg::PH_GFLAGS: begin
					grants_d = acc_sh[2:0] & mffp_pkg::GRANT_MASK;
					if ((acc_sh[2:0] & mffp_pkg::GRANT_MASK) == 3'd0) begin
						phase_adv = mffp_pkg::PH_SYNC;
					end else begin
						grant_d   = 3'd1;
						phase_adv = mffp_pkg::PH_GSTART;
					end
				end
				mffp_pkg::PH_GSTART: begin
					phase_adv = mffp_pkg::PH_GLEN;
				end
				mffp_pkg::PH_GLEN: begin
					if (grant_q >= grants_q) begin
						phase_adv = mffp_pkg::PH_SYNC;
					end else begin
						grant_d   = grant_q + 3'd1;
						phase_adv = mffp_pkg::PH_GSTART;
					end
				end
				mffp_pkg::PH_SETCNT: begin
					sets_d = acc_sh[7:0];
					if (acc_sh[7:0] == 8'd0) begin
						phase_adv = mffp_pkg::PH_SKIP;
					end else begin
						set_d     = 8'd1;
						phase_adv = mffp_pkg::PH_BITMAP;
					end
				end
				mffp_pkg::PH_BITMAP, mffp_pkg::PH_QREP: begin
					// pick next queue, or move to the next set, or end the body after the last set
					bitmap_d = bm_src;
					if (bm_src == 8'd0) begin
						queue_d = 4'd0;
						if (set_q >= sets_q) begin
							phase_adv = mffp_pkg::PH_SKIP;
						end else begin
							set_d     = set_q + 8'd1;
							phase_adv = mffp_pkg::PH_BITMAP;
						end
					end else begin
						queue_d   = low_idx;
						phase_adv = mffp_pkg::PH_QREP;
					end
				end
				default: begin
					if (phase_q == mffp_pkg::PH_SYNC || phase_q == mffp_pkg::PH_RR_PEND ||
						phase_q == mffp_pkg::PH_R_PEND || phase_q == mffp_pkg::PH_A_SYNC) begin
						phase_adv = mffp_pkg::PH_SKIP;
					end else begin
						phase_adv = mffp_pkg::phase_t'(phase_q + 5'd1);
					end
				end
			endcase
		end

		// clear per-frame state on the last byte
		phase_d = phase_adv;
		if (frame_end) begin
			phase_d  = mffp_pkg::PH_OPC;
			bif_d    = '0;
			acc_d    = '0;
			opcode_d = '0;
			grants_d = '0;
			grant_d  = '0;
			sets_d   = '0;
			set_d    = '0;
			bitmap_d = '0;
			queue_d  = '0;
		end
	end

	// records for the byte
	always_comb begin
		rec0       = '0;
		rec1       = '0;
		rec0_valid = 1'b0;
		rec1_valid = 1'b0;
		r_end      = '0;

		// field record
		if (done) begin
			rec0.value = acc_sh;
			rec0_valid = 1'b1;
			unique case (phase_q)
				mffp_pkg::PH_OPC: begin
					rec0.kind  = mffp_pkg::KIND_OPCODE;
					rec0.value = {16'd0, acc_sh[15:0]};
				end
				mffp_pkg::PH_TS: begin
					rec0.kind  = mffp_pkg::KIND_TS;
					rec0_valid = (opcode_q != mffp_pkg::OP_PAUSE);
				end
				mffp_pkg::PH_GFLAGS: begin
					rec0.kind = mffp_pkg::KIND_GFLAGS;
				end
				mffp_pkg::PH_GSTART: begin
					rec0.kind     = mffp_pkg::KIND_GSTART;
					rec0.item_num = {1'b0, grant_q};
				end
				mffp_pkg::PH_GLEN: begin
					rec0.kind     = mffp_pkg::KIND_GLEN;
					rec0.item_num = {1'b0, grant_q};
				end
				mffp_pkg::PH_SETCNT: begin
					rec0.kind = mffp_pkg::KIND_SETCNT;
				end
				mffp_pkg::PH_BITMAP: begin
					rec0.kind    = mffp_pkg::KIND_BITMAP;
					rec0.set_num = set_q;
				end
				mffp_pkg::PH_QREP: begin
					rec0.kind     = mffp_pkg::KIND_QREP;
					rec0.set_num  = set_q;
					rec0.item_num = queue_q;
				end
				default: begin
					rec0.kind = phase_q;
				end
			endcase
		end

		// end of frame record after any field record
		if (frame_end) begin
			r_end.kind = (phase_adv == mffp_pkg::PH_SKIP) ?
				mffp_pkg::KIND_END_OK : mffp_pkg::KIND_TRUNC;
			r_end.last = 1'b1;
			if (rec0_valid) begin
				rec1       = r_end;
				rec1_valid = 1'b1;
			end else begin
				rec0       = r_end;
				rec0_valid = 1'b1;
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mffp_pkg::PH_OPC;
			bif_q    <= '0;
			acc_q    <= '0;
			opcode_q <= '0;
			grants_q <= '0;
			grant_q  <= '0;
			sets_q   <= '0;
			set_q    <= '0;
			bitmap_q <= '0;
			queue_q  <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			bif_q    <= bif_d;
			acc_q    <= acc_d;
			opcode_q <= opcode_d;
			grants_q <= grants_d;
			grant_q  <= grant_d;
			sets_q   <= sets_d;
			set_q    <= set_d;
			bitmap_q <= bitmap_d;
			queue_q  <= queue_d;
		end
	end

endmodule

### hw/rtl/mffp_fifo.sv
module mffp_fifo #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr0,
	input  mffp_pkg::record_t  wdata0,
	input  logic               wr1,
	input  mffp_pkg::record_t  wdata1,
	input  logic               rd,
	output mffp_pkg::record_t  rdata,
	output logic               not_empty,
	output logic               room
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	mffp_pkg::record_t mem_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, tail1;
	logic [CNT_W-1:0] count_q, count_d;
	logic             room_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	assign tail1     = ptr_next(tail_q);
	assign rdata     = mem_q[head_q];
	assign not_empty = (count_q != '0);
	assign room      = room_q;
	assign count_d   = count_q + CNT_W'(wr0) + CNT_W'(wr1) - CNT_W'(rd);

	// storage, one or two beats written per cycle
	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[tail_q] <= wdata0;
		end
		if (wr1) begin
			mem_q[tail1] <= wdata1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			room_q  <= 1'b1;
		end else begin
			if (rd) begin
				head_q <= ptr_next(head_q);
			end
			if (wr1) begin
				tail_q <= ptr_next(tail1);
			end else if (wr0) begin
				tail_q <= tail1;
			end
			count_q <= count_d;
			room_q  <= (count_d <= CNT_W'(DEPTH - 2));
		end
	end

endmodule

### tb/sv/mpcp_frame_field_parser_tb.sv
module mpcp_frame_field_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 9;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE       = 3;
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 165;
	localparam int HOLD_CYCLES  = 60;

	// receiver and sender idling modes
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// one line of the directed stimulus table
	typedef struct {
		bit          is_cfg;
		logic [7:0]  b;
		logic        e;
		bit          typed;
		logic [4:0]  kind;
		logic [31:0] val;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        frame_end;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  field_kind;
	logic [7:0]  set_number;
	logic [3:0]  item_number;
	logic [31:0] value;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	// parser state mirrored on the testbench side
	mffp_pkg::phase_t ps_phase;
	logic [2:0]  ps_nbytes;
	logic [31:0] ps_acc;
	logic [15:0] ps_opcode;
	logic [2:0]  ps_grants;
	logic [2:0]  ps_grant_idx;
	logic [7:0]  ps_sets;
	logic [7:0]  ps_set_idx;
	logic [7:0]  ps_bitmap;
	logic [3:0]  ps_queue;
	logic        verbose_shadow;

	mffp_pkg::record_t step_recs[$];
	mffp_pkg::record_t expected_records[$];
	stim_row_t   stim_rows[$];
	logic [7:0]  frame_bytes[$];

	int tx_pct;
	int rx_pct;
	int hold_left;
	int errors;
	int quiet_cycles;

	mpcp_frame_field_parser i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.field_kind  (field_kind),
		.set_number  (set_number),
		.item_number (item_number),
		.value       (value),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// length in bytes of the field read in each phase
	function automatic logic [2:0] bytes_for(input mffp_pkg::phase_t ph);
		case (ph)
			mffp_pkg::PH_TS, mffp_pkg::PH_GSTART: return 3'd4;
			mffp_pkg::PH_OPC, mffp_pkg::PH_GLEN, mffp_pkg::PH_SYNC, mffp_pkg::PH_QREP,
			mffp_pkg::PH_R_PORT, mffp_pkg::PH_R_SYNC, mffp_pkg::PH_A_PORT,
			mffp_pkg::PH_A_SYNC: return 3'd2;
			mffp_pkg::PH_SKIP: return 3'd0;
			default: return 3'd1;
		endcase
	endfunction

	// queue number plus one of the lowest bit still pending
	function automatic logic [3:0] first_queue(input logic [7:0] bits);
		for (int i = 0; i < 8; i++) begin
			if (bits[i]) return 4'(i + 1);
		end
		return 4'd0;
	endfunction

	function automatic void add_record(input logic [4:0] kind, input logic [7:0] set_n,
			input logic [3:0] item_n, input logic [31:0] val, input logic lst);
		mffp_pkg::record_t r;
		r.kind     = kind;
		r.set_num  = set_n;
		r.item_num = item_n;
		r.value    = val;
		r.last     = lst;
		step_recs.push_back(r);
	endfunction

	task automatic clear_parse();
		ps_phase     = mffp_pkg::PH_OPC;
		ps_nbytes    = '0;
		ps_acc       = '0;
		ps_opcode    = '0;
		ps_grants    = '0;
		ps_grant_idx = '0;
		ps_sets      = '0;
		ps_set_idx   = '0;
		ps_bitmap    = '0;
		ps_queue     = '0;
	endtask

	// step to the next queue report, the next set's bitmap, or the end of the body
	task automatic next_queue_or_set();
		if (ps_bitmap == 8'd0) begin
			ps_queue = 4'd0;
			if (ps_set_idx >= ps_sets) begin
				ps_phase = mffp_pkg::PH_SKIP;
			end else begin
				ps_set_idx = ps_set_idx + 8'd1;
				ps_phase   = mffp_pkg::PH_BITMAP;
			end
		end else begin
			ps_queue = first_queue(ps_bitmap);
			ps_phase = mffp_pkg::PH_QREP;
		end
	endtask

	// records that one frame byte yields, left in step_recs
	task automatic parse_byte(input logic [7:0] b, input logic e);
		logic [31:0]      v;
		mffp_pkg::phase_t ph;
		step_recs.delete();
		if (ps_phase != mffp_pkg::PH_SKIP) begin
			ps_acc    = {ps_acc[23:0], b};
			ps_nbytes = ps_nbytes + 3'd1;
			if (ps_nbytes >= bytes_for(ps_phase)) begin
				v         = ps_acc;
				ph        = ps_phase;
				ps_acc    = '0;
				ps_nbytes = '0;
				case (ph)
					mffp_pkg::PH_OPC: begin
						ps_opcode = v[15:0];
						add_record(mffp_pkg::KIND_OPCODE, 8'd0, 4'd0, {16'd0, ps_opcode}, 1'b0);
						ps_phase = mffp_pkg::PH_TS;
					end
					mffp_pkg::PH_TS: begin
						// pause frames carry no timestamp record
						if (ps_opcode != mffp_pkg::OP_PAUSE)
							add_record(mffp_pkg::KIND_TS, 8'd0, 4'd0, v, 1'b0);
						if (!verbose_shadow) begin
							ps_phase = mffp_pkg::PH_SKIP;
						end else begin
							case (ps_opcode)
								mffp_pkg::OP_GATE:    ps_phase = mffp_pkg::PH_GFLAGS;
								mffp_pkg::OP_REPORT:  ps_phase = mffp_pkg::PH_SETCNT;
								mffp_pkg::OP_REG_REQ: ps_phase = mffp_pkg::PH_RR_FLAGS;
								mffp_pkg::OP_REG:     ps_phase = mffp_pkg::PH_R_PORT;
								mffp_pkg::OP_REG_ACK: ps_phase = mffp_pkg::PH_A_FLAGS;
								default:              ps_phase = mffp_pkg::PH_SKIP;
							endcase
						end
					end
					mffp_pkg::PH_GFLAGS: begin
						add_record(mffp_pkg::KIND_GFLAGS, 8'd0, 4'd0, v, 1'b0);
						ps_grants = v[2:0] & mffp_pkg::GRANT_MASK;
						if (ps_grants == 3'd0) begin
							ps_phase = mffp_pkg::PH_SYNC;
						end else begin
							ps_grant_idx = 3'd1;
							ps_phase     = mffp_pkg::PH_GSTART;
						end
					end
					mffp_pkg::PH_GSTART: begin
						add_record(mffp_pkg::KIND_GSTART, 8'd0, {1'b0, ps_grant_idx}, v, 1'b0);
						ps_phase = mffp_pkg::PH_GLEN;
					end
					mffp_pkg::PH_GLEN: begin
						add_record(mffp_pkg::KIND_GLEN, 8'd0, {1'b0, ps_grant_idx}, v, 1'b0);
						if (ps_grant_idx >= ps_grants) begin
							ps_phase = mffp_pkg::PH_SYNC;
						end else begin
							ps_grant_idx = ps_grant_idx + 3'd1;
							ps_phase     = mffp_pkg::PH_GSTART;
						end
					end
					mffp_pkg::PH_SETCNT: begin
						add_record(mffp_pkg::KIND_SETCNT, 8'd0, 4'd0, v, 1'b0);
						ps_sets = v[7:0];
						if (ps_sets == 8'd0) begin
							ps_phase = mffp_pkg::PH_SKIP;
						end else begin
							ps_set_idx = 8'd1;
							ps_phase   = mffp_pkg::PH_BITMAP;
						end
					end
					mffp_pkg::PH_BITMAP: begin
						add_record(mffp_pkg::KIND_BITMAP, ps_set_idx, 4'd0, v, 1'b0);
						ps_bitmap = v[7:0];
						next_queue_or_set();
					end
					mffp_pkg::PH_QREP: begin
						add_record(mffp_pkg::KIND_QREP, ps_set_idx, ps_queue, v, 1'b0);
						if (ps_queue >= 4'd1 && ps_queue <= 4'd8)
							ps_bitmap[ps_queue - 4'd1] = 1'b0;
						next_queue_or_set();
					end
					default: begin
						// plain fields: the record kind is the phase code
						add_record(5'(ph), 8'd0, 4'd0, v, 1'b0);
						if (ph == mffp_pkg::PH_SYNC || ph == mffp_pkg::PH_RR_PEND ||
								ph == mffp_pkg::PH_R_PEND || ph == mffp_pkg::PH_A_SYNC)
							ps_phase = mffp_pkg::PH_SKIP;
						else
							ps_phase = mffp_pkg::phase_t'(ph + 5'd1);
					end
				endcase
			end
		end
		if (e) begin
			add_record(ps_phase == mffp_pkg::PH_SKIP ? mffp_pkg::KIND_END_OK :
				mffp_pkg::KIND_TRUNC, 8'd0, 4'd0, 32'd0, 1'b1);
			clear_parse();
		end
	endtask

	// one input beat, entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
			input mffp_pkg::record_t typed_rec);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= e;
		do @(posedge clk); while (in_stall);
		parse_byte(b, e);
		// a hand-written expectation stands in for the byte's final record
		if (typed) begin
			if (step_recs.size() > 0) step_recs[step_recs.size() - 1] = typed_rec;
			else step_recs.push_back(typed_rec);
		end
		foreach (step_recs[k]) expected_records.push_back(step_recs[k]);
		@(negedge clk);
	endtask

	// verbose write once every record has drained
	task automatic set_verbose(input logic v);
		while (expected_records.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		verbose_shadow = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void stim_row(input bit is_cfg, input logic [7:0] b, input logic e,
			input bit typed, input logic [4:0] kind, input logic [31:0] val);
		stim_row_t r;
		r.is_cfg = is_cfg;
		r.b      = b;
		r.e      = e;
		r.typed  = typed;
		r.kind   = kind;
		r.val    = val;
		stim_rows.push_back(r);
	endfunction

	// random frame: mostly well formed, some cut short, some plain noise
	task automatic make_frame();
		logic [15:0] opc;
		logic [7:0]  fl;
		logic [7:0]  bm;
		int          sel;
		int          n;
		frame_bytes.delete();
		sel = $urandom_range(0, 7);
		if (sel == 7) begin
			n = $urandom_range(1, 12);
			repeat (n) frame_bytes.push_back(8'($urandom));
			return;
		end
		case (sel)
			0: opc = mffp_pkg::OP_PAUSE;
			1: opc = mffp_pkg::OP_GATE;
			2: opc = mffp_pkg::OP_REPORT;
			3: opc = mffp_pkg::OP_REG_REQ;
			4: opc = mffp_pkg::OP_REG;
			5: opc = mffp_pkg::OP_REG_ACK;
			default: opc = 16'($urandom);
		endcase
		frame_bytes.push_back(opc[15:8]);
		frame_bytes.push_back(opc[7:0]);
		repeat (4) frame_bytes.push_back(8'($urandom));
		case (opc)
			mffp_pkg::OP_GATE: begin
				fl = 8'($urandom);
				frame_bytes.push_back(fl);
				for (int g = 0; g < int'(fl[2:0]); g++)
					repeat (6) frame_bytes.push_back(8'($urandom));
				repeat (2) frame_bytes.push_back(8'($urandom));
			end
			mffp_pkg::OP_REPORT: begin
				// now and then a long run of mostly empty queue sets
				if ($urandom_range(59) == 0) n = $urandom_range(128, 255);
				else n = $urandom_range(0, 3);
				frame_bytes.push_back(8'(n));
				for (int s = 0; s < n; s++) begin
					if (n > 8) bm = ($urandom_range(15) == 0) ? 8'($urandom) : 8'd0;
					else bm = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
					frame_bytes.push_back(bm);
					for (int q = 0; q < 8; q++) begin
						if (bm[q]) repeat (2) frame_bytes.push_back(8'($urandom));
					end
				end
			end
			mffp_pkg::OP_REG_REQ: repeat (2) frame_bytes.push_back(8'($urandom));
			mffp_pkg::OP_REG:     repeat (6) frame_bytes.push_back(8'($urandom));
			mffp_pkg::OP_REG_ACK: repeat (5) frame_bytes.push_back(8'($urandom));
			default: repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
		endcase
		// trailing pad bytes
		if ($urandom_range(2) == 0)
			repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
		// cut short
		if ($urandom_range(7) == 0) begin
			n = $urandom_range(1, frame_bytes.size());
			while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
		end
	endtask

	// receiver: long hold when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	// compare each output beat with the oldest expected record
	always @(posedge clk) begin : check_records
		mffp_pkg::record_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_records.size() == 0) begin
				$error("unexpected record: field_kind %0d value %h", field_kind, value);
				errors++;
			end else begin
				want = expected_records.pop_front();
				if (field_kind !== want.kind) begin
					$error("field_kind: expected %0d, got %0d", want.kind, field_kind);
					errors++;
				end
				if (set_number !== want.set_num) begin
					$error("set_number: expected %0d, got %0d", want.set_num, set_number);
					errors++;
				end
				if (item_number !== want.item_num) begin
					$error("item_number: expected %0d, got %0d", want.item_num, item_number);
					errors++;
				end
				if (value !== want.value) begin
					$error("value: expected %h, got %h", want.value, value);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mffp_pkg::record_t rec;
		int         sent;
		idle_mode_t mode;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = 8'd0;
		frame_end    = 1'b0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = 1'b0;
		tx_pct       = 0;
		rx_pct       = 0;
		hold_left    = 0;
		errors       = 0;
		quiet_cycles = 0;
		verbose_shadow = 1'b1;
		clear_parse();

		// lone byte after reset ends the frame
		stim_row(0, 8'h00, 1'b1, 1, mffp_pkg::KIND_TRUNC, 32'd0);
		// report, one queue set with an empty bitmap ending the frame
		stim_row(0, 8'h00, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h03, 1'b0, 1, mffp_pkg::KIND_OPCODE, {16'd0, mffp_pkg::OP_REPORT});
		stim_row(0, 8'hFF, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'hFF, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'hFF, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'hFF, 1'b0, 1, mffp_pkg::KIND_TS, 32'hFFFF_FFFF);
		stim_row(0, 8'h01, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h00, 1'b1, 1, mffp_pkg::KIND_END_OK, 32'd0);
		// gate with verbose cleared before the timestamp completes: body ignored
		stim_row(0, 8'h00, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h02, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h00, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h00, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(1, 8'd0,  1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h00, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h00, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'hF8, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h55, 1'b1, 1, mffp_pkg::KIND_END_OK, 32'd0);
		// gate with zero grants, sync time and frame end on the same byte
		stim_row(1, 8'd1,  1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h00, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h02, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h12, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h34, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h56, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'h78, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'hF8, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'hAB, 1'b0, 0, mffp_pkg::KIND_OPCODE, 32'd0);
		stim_row(0, 8'hCD, 1'b1, 1, mffp_pkg::KIND_END_OK, 32'd0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_cfg) begin
				in_valid <= 1'b0;
				set_verbose(stim_rows[i].b[0]);
			end else begin
				rec       = '0;
				rec.kind  = stim_rows[i].kind;
				rec.value = stim_rows[i].val;
				rec.last  = (stim_rows[i].kind == mffp_pkg::KIND_END_OK ||
					stim_rows[i].kind == mffp_pkg::KIND_TRUNC);
				send_byte(stim_rows[i].b, stim_rows[i].e, stim_rows[i].typed, rec);
			end
		end

		// random frames over idling modes and both verbose settings
		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			set_verbose(((p + p / 4) % 2) == 0);
			mode = idle_mode_t'(p % 4);
			case (mode)
				IDLE_NONE:     begin tx_pct = 0;  rx_pct = 0;  end
				IDLE_SENDER:   begin tx_pct = 56; rx_pct = 0;  end
				IDLE_RECEIVER: begin tx_pct = 0;  rx_pct = 56; end
				default:       begin tx_pct = 7;  rx_pct = 7;  end
			endcase
			// back the output queue up into the input
			if (mode == IDLE_RECEIVER) hold_left = HOLD_CYCLES;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				make_frame();
				foreach (frame_bytes[i])
					send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 0, '0);
				sent += frame_bytes.size();
			end
		end

		in_valid <= 1'b0;
		while (expected_records.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mffp_pkg.sv
hw/rtl/mffp_core.sv
hw/rtl/mffp_fifo.sv
hw/rtl/mpcp_frame_field_parser.sv
tb/sv/mpcp_frame_field_parser_tb.sv
